/* sv/btpc_pkg.sv */
// Shared types, constants and helpers for the barometric compensation block.
`default_nettype none
package btpc_pkg;

	localparam int RAW_W     = 20;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 2;

	localparam logic [63:0] FINE_OFFSET = 64'd128000;
	localparam logic [63:0] PRESS_BASE  = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE = 64'd3125;
	localparam logic [63:0] DIV_BIAS    = 64'd1 << 47;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP      = 2'd0,
		CFG_PRESS_LOW = 2'd1,
		CFG_PRESS_MID = 2'd2,
		CFG_PRESS_HIGH = 2'd3
	} cfg_idx_t;

	// Datapath steps. Most steps consume the last product and start the next unit.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_T_LOAD, OP_T_V1, OP_T_BB, OP_T_FIN,
		OP_P_LOAD, OP_P_T, OP_P_V2A, OP_P_V2B, OP_P_W, OP_P_X, OP_P_D,
		OP_P_N, OP_P_Q, OP_P_A, OP_P_B, OP_P_FIN
	} dp_op_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic dzero;
		logic out_free;
	} dp_status_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

endpackage
`default_nettype wire

/* sv/btpc_ifs.sv */
// Valid/ready channel interfaces for sample words and result words.
`default_nettype none
interface btpc_in_if import btpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             action;
	logic [RAW_W-1:0] raw_sample;
	modport source(output valid, action, raw_sample, input ready);
	modport sink(input valid, action, raw_sample, output ready);
endinterface

interface btpc_out_if ();
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic signed [31:0] comp_value;
	logic        divide_fault;
	modport source(output valid, result_kind, comp_value, divide_fault, input ready);
	modport sink(input valid, result_kind, comp_value, divide_fault, output ready);
endinterface
`default_nettype wire

/* sv/btpc_div.sv */
// Serial signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module btpc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [63:0] den,
	output logic             busy,
	output logic [63:0]      quo
);
	logic [63:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        neg_q, busy_q;
	logic [64:0] shifted, diff;

	assign shifted = {rem_q, quo_q[63]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num[63] ? 64'd0 - num : num;
			den_q <= den[63] ? 64'd0 - den : den;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? 64'd0 - quo_q : quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q && cnt_q == 6'd0)
		else $error("divider did not begin its run");
endmodule
`default_nettype wire

/* sv/btpc_dp.sv */
// Datapath: coefficient and working registers, shared multiplier, divider and result register.
`default_nettype none
module btpc_dp import btpc_pkg::*; #(
	parameter int RAW_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_action,
	input  wire logic [RAW_W-1:0]     in_raw,
	input  wire dp_cmd_t              cmd,
	output dp_status_t                status,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic                      out_kind,
	output logic [31:0]               out_value,
	output logic                      out_fault
);
	localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((64'd1 << RAW_BITS) - 64'd1);

	logic [CFG_W-1:0] tc_q, pl_q, pm_q, ph_q;
	logic [31:0]      fine_q;
	logic [RAW_W-1:0] adc_q;
	logic             kind_q, fault_q;
	logic [63:0]      r0_q, r1_q, r2_q, r3_q;
	logic [63:0]      r0_d, r1_d, r2_d, r3_d;
	logic [31:0]      fine_d;
	logic             fault_d;

	logic        mul_go, mbusy_q;
	logic [1:0]  mcnt_q;
	logic [63:0] ma_d, mb_d, ma_q, mb_q, prod_q;
	logic [31:0] mx, my;
	logic [63:0] mprod;

	logic        div_go, div_busy;
	logic [63:0] div_quo;

	logic        res_we, res_fault;
	logic [31:0] res_val;

	logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, adc64;
	logic [31:0] ta, tb, bb, tv2, tfine;
	logic [63:0] nv, dv, q13, psum;

	assign t1 = {48'd0, tc_q[15:0]};
	assign t2 = sx16(tc_q[31:16]);
	assign t3 = sx16(tc_q[47:32]);
	assign p1 = {48'd0, pl_q[15:0]};
	assign p2 = sx16(pl_q[31:16]);
	assign p3 = sx16(pl_q[47:32]);
	assign p4 = sx16(pm_q[15:0]);
	assign p5 = sx16(pm_q[31:16]);
	assign p6 = sx16(pm_q[47:32]);
	assign p7 = sx16(ph_q[15:0]);
	assign p8 = sx16(ph_q[31:16]);
	assign p9 = sx16(ph_q[47:32]);
	assign adc64 = {{(64-RAW_W){1'b0}}, adc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
			pl_q <= '0;
			pm_q <= '0;
			ph_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TEMP:       tc_q <= cfg_data;
				CFG_PRESS_LOW:  pl_q <= cfg_data;
				CFG_PRESS_MID:  pm_q <= cfg_data;
				CFG_PRESS_HIGH: ph_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ta    = 32'(adc64 >> 3) - 32'(t1 << 1);
		tb    = 32'(adc64 >> 4) - t1[31:0];
		bb    = 32'($signed(prod_q[31:0]) >>> 12);
		tv2   = 32'($signed(prod_q[31:0]) >>> 14);
		tfine = r0_q[31:0] + tv2;
		nv    = r3_q + (prod_q << 12);
		dv    = 64'($signed(prod_q) >>> 33);
		q13   = 64'($signed(div_quo) >>> 13);
		psum  = r0_q + r2_q + 64'($signed(prod_q) >>> 19);

		r0_d = r0_q; r1_d = r1_q; r2_d = r2_q; r3_d = r3_q;
		fine_d = fine_q; fault_d = fault_q;
		ma_d = ma_q; mb_d = mb_q;
		mul_go = 1'b1; div_go = 1'b0;
		res_we = 1'b0; res_val = '0; res_fault = 1'b0;
		unique case (cmd.op)
			OP_T_LOAD: begin
				r1_d = {32'd0, tb};
				ma_d = {{32{ta[31]}}, ta};
				mb_d = t2;
			end
			OP_T_V1: begin
				r0_d = {32'd0, 32'($signed(prod_q[31:0]) >>> 11)};
				ma_d = r1_q;
				mb_d = r1_q;
			end
			OP_T_BB: begin
				ma_d = {{32{bb[31]}}, bb};
				mb_d = t3;
			end
			OP_T_FIN: begin
				mul_go = 1'b0;
				fine_d = tfine;
				res_we = 1'b1;
				res_val = 32'($signed((tfine << 2) + tfine + 32'd128) >>> 8);
			end
			OP_P_LOAD: begin
				r0_d = {{32{fine_q[31]}}, fine_q} - FINE_OFFSET;
				fault_d = 1'b0;
				ma_d = r0_d;
				mb_d = r0_d;
			end
			OP_P_T: begin
				r1_d = prod_q;
				ma_d = prod_q;
				mb_d = p6;
			end
			OP_P_V2A: begin
				r2_d = prod_q;
				ma_d = r0_q;
				mb_d = p5;
			end
			OP_P_V2B: begin
				r2_d = r2_q + (prod_q << 17) + (p4 << 35);
				ma_d = r1_q;
				mb_d = p3;
			end
			OP_P_W: begin
				r3_d = 64'($signed(prod_q) >>> 8);
				ma_d = r0_q;
				mb_d = p2;
			end
			OP_P_X: begin
				ma_d = nv + DIV_BIAS;
				mb_d = p1;
			end
			OP_P_D: begin
				r1_d = dv;
				fault_d = (dv == 64'd0);
				ma_d = ((PRESS_BASE - adc64) << 31) - r2_q;
				mb_d = PRESS_SCALE;
			end
			OP_P_N: begin
				mul_go = 1'b0;
				div_go = 1'b1;
			end
			OP_P_Q: begin
				r0_d = div_quo;
				r1_d = q13;
				ma_d = p9;
				mb_d = q13;
			end
			OP_P_A: begin
				ma_d = prod_q;
				mb_d = r1_q;
			end
			OP_P_B: begin
				r2_d = 64'($signed(prod_q) >>> 25);
				ma_d = p8;
				mb_d = r0_q;
			end
			OP_P_FIN: begin
				mul_go = 1'b0;
				res_we = 1'b1;
				res_fault = fault_q;
				res_val = fault_q ? 32'd0 : 32'(64'($signed(psum) >>> 8) + (p7 << 4));
			end
			default: mul_go = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q  <= '0;
			fault_q <= 1'b0;
		end else begin
			fine_q  <= fine_d;
			fault_q <= fault_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_action;
			adc_q  <= in_raw & ADC_MASK;
		end
		r0_q <= r0_d;
		r1_q <= r1_d;
		r2_q <= r2_d;
		r3_q <= r3_d;
	end

	// The 64x64 product is kept to its low 64 bits: low*low, then two cross terms.
	always_comb begin
		unique case (mcnt_q)
			2'd1:    begin mx = ma_q[63:32]; my = mb_q[31:0];  end
			2'd2:    begin mx = ma_q[31:0];  my = mb_q[63:32]; end
			default: begin mx = ma_q[31:0];  my = mb_q[31:0];  end
		endcase
		mprod = {32'd0, mx} * {32'd0, my};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q  <= '0;
		end else if (mul_go) begin
			mbusy_q <= 1'b1;
			mcnt_q  <= '0;
		end else if (mbusy_q) begin
			mcnt_q <= mcnt_q + 2'd1;
			if (mcnt_q == 2'd2) begin
				mbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			ma_q <= ma_d;
			mb_q <= mb_d;
		end else if (mbusy_q) begin
			if (mcnt_q == 2'd0) begin
				prod_q <= mprod;
			end else begin
				prod_q[63:32] <= prod_q[63:32] + mprod[31:0];
			end
		end
	end

	btpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (prod_q),
		.den    (r1_q),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_we) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			out_kind  <= kind_q;
			out_value <= res_val;
			out_fault <= res_fault;
		end
	end

	assign status.busy     = mbusy_q | div_busy;
	assign status.dzero    = fault_q;
	assign status.out_free = !out_valid || out_ready;

	assert property (@(posedge clk) disable iff (!arst_n) mul_go |-> !mbusy_q && !div_busy)
		else $error("multiplier started while a unit is busy");
	assert property (@(posedge clk) disable iff (!arst_n) div_go |-> r1_q != 64'd0)
		else $error("divider started with a zero divisor");
	assert property (@(posedge clk) disable iff (!arst_n) res_we |-> !out_valid || out_ready)
		else $error("result register overwritten before it was taken");
endmodule
`default_nettype wire

/* sv/btpc_ctrl.sv */
// Controller: steps the datapath through the temperature or pressure sequence.
`default_nettype none
module btpc_ctrl import btpc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_action,
	output logic            in_ready,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);
	typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_DONE} state_t;

	state_t state_q;
	dp_op_t op_q;

	function automatic dp_op_t next_op(input dp_op_t op);
		dp_op_t n;
		unique case (op)
			OP_T_LOAD: n = OP_T_V1;
			OP_T_V1:   n = OP_T_BB;
			OP_P_LOAD: n = OP_P_T;
			OP_P_T:    n = OP_P_V2A;
			OP_P_V2A:  n = OP_P_V2B;
			OP_P_V2B:  n = OP_P_W;
			OP_P_W:    n = OP_P_X;
			OP_P_X:    n = OP_P_D;
			OP_P_D:    n = OP_P_N;
			OP_P_N:    n = OP_P_Q;
			OP_P_Q:    n = OP_P_A;
			OP_P_A:    n = OP_P_B;
			default:   n = OP_NONE;
		endcase
		return n;
	endfunction

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.op      = (state_q == S_RUN || (state_q == S_DONE && status.out_free))
		? op_q : OP_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_action ? OP_P_LOAD : OP_T_LOAD;
						state_q <= S_RUN;
					end
				end
				S_RUN: state_q <= S_WAIT;
				S_WAIT: begin
					if (!status.busy) begin
						priority if (op_q == OP_T_BB) begin
							op_q    <= OP_T_FIN;
							state_q <= S_DONE;
						end else if (op_q == OP_P_B || (op_q == OP_P_D && status.dzero)) begin
							op_q    <= OP_P_FIN;
							state_q <= S_DONE;
						end else begin
							op_q    <= next_op(op_q);
							state_q <= S_RUN;
						end
					end
				end
				S_DONE: begin
					if (status.out_free) begin
						op_q    <= OP_NONE;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |=> state_q == S_WAIT && status.busy)
		else $error("issued step started no unit");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> op_q == OP_T_FIN || op_q == OP_P_FIN)
		else $error("finish state without a finishing step");
endmodule
`default_nettype wire

/* sv/baro_temp_press_compensation.sv */
// Top level of the barometric temperature and pressure compensation block.
//
//  channel | dir | handshake        | word
//  in_ch   | in  | valid/ready      | action, raw_sample
//  out_ch  | out | valid/ready      | result_kind, comp_value, divide_fault
//  cfg     | in  | cfg_we, no ready | cfg_index, cfg_data (48 bits)
//
// Words are handled one at a time; each product takes three passes of the
// shared 32x32 multiplier, and a pressure word also runs the serial divider.
// A zero divisor skips the division. Reset clears the coefficients and the
// fine temperature. A new word is taken while the previous result still
// waits in the output register.
`default_nettype none
module baro_temp_press_compensation import btpc_pkg::*; #(
	parameter int RAW_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	btpc_in_if.sink                   in_ch,
	btpc_out_if.source                out_ch
);
	dp_cmd_t    cmd;
	dp_status_t status;
	logic       ready;
	logic [31:0] value;

	btpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_action (in_ch.action),
		.in_ready  (ready),
		.status    (status),
		.cmd       (cmd)
	);

	btpc_dp #(.RAW_BITS(RAW_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_action (in_ch.action),
		.in_raw    (in_ch.raw_sample),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_kind  (out_ch.result_kind),
		.out_value (value),
		.out_fault (out_ch.divide_fault)
	);

	assign in_ch.ready       = ready;
	assign out_ch.comp_value = $signed(value);
endmodule
`default_nettype wire

/* verif/tb_baro_temp_press_compensation.sv */
// Self-checking testbench for the barometric temperature and pressure compensation block.
`default_nettype none
module tb_baro_temp_press_compensation import btpc_pkg::*; ();

	localparam int WATCHDOG_CYCLES = 6000;
	localparam int DRAIN_CYCLES    = 300;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic        fault;
	} comp_word_t;

	typedef struct {
		logic        action;
		logic [19:0] raw;
		bit          known;
		logic [31:0] value;
		logic        fault;
	} sample_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	btpc_in_if in_ch ();
	btpc_out_if out_ch ();

	baro_temp_press_compensation uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	// Predictor state: coefficient registers and the held fine temperature.
	logic [47:0] temp_k, press_lo_k, press_mid_k, press_hi_k;
	logic [31:0] held_fine;

	comp_word_t pending_words[$];
	int mismatches = 0;
	int temp_seen = 0, press_seen = 0, faults_seen = 0;
	int sender_idle_pct = 0, sink_stall_pct = 0;
	int quiet_cycles = 0;

	function automatic logic [31:0] shr32(input logic [31:0] v, input int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [63:0] shr64(input logic [63:0] v, input int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [63:0] ext16(input logic [47:0] r, input int slot);
		logic [15:0] f;
		f = 16'(r >> (16 * slot));
		return {{48{f[15]}}, f};
	endfunction

	// Signed division truncating toward zero; the most negative quotient wraps.
	function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] an, ad, q;
		an = n[63] ? -n : n;
		ad = d[63] ? -d : d;
		q = an / ad;
		return (n[63] != d[63]) ? -q : q;
	endfunction

	function automatic comp_word_t compensate(input logic action, input logic [19:0] adc);
		comp_word_t w;
		logic [31:0] t1, t2, t3, a, tv1, b, tv2;
		logic [63:0] ft, v1, v2, p, ps, p1;
		w.kind = action;
		w.fault = 1'b0;
		if (action == 1'b0) begin
			t1 = {16'b0, temp_k[15:0]};
			t2 = {{16{temp_k[31]}}, temp_k[31:16]};
			t3 = {{16{temp_k[47]}}, temp_k[47:32]};
			a = ({12'b0, adc} >> 3) - (t1 << 1);
			tv1 = shr32(a * t2, 11);
			b = ({12'b0, adc} >> 4) - t1;
			tv2 = shr32(shr32(b * b, 12) * t3, 14);
			held_fine = tv1 + tv2;
			w.value = shr32(held_fine * 32'd5 + 32'd128, 8);
		end else begin
			p1 = {48'b0, press_lo_k[15:0]};
			ft = {{32{held_fine[31]}}, held_fine};
			v1 = ft - 64'd128000;
			v2 = v1 * v1 * ext16(press_mid_k, 2);
			v2 = v2 + ((v1 * ext16(press_mid_k, 1)) << 17);
			v2 = v2 + (ext16(press_mid_k, 0) << 35);
			v1 = shr64(v1 * v1 * ext16(press_lo_k, 2), 8) + ((v1 * ext16(press_lo_k, 1)) << 12);
			v1 = shr64(((64'd1 << 47) + v1) * p1, 33);
			if (v1 == 64'd0) begin
				w.fault = 1'b1;
				w.value = '0;
			end else begin
				p = 64'd1048576 - {44'b0, adc};
				p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
				ps = shr64(p, 13);
				v1 = shr64(ext16(press_hi_k, 2) * ps * ps, 25);
				v2 = shr64(ext16(press_hi_k, 1) * p, 19);
				p = shr64(p + v1 + v2, 8) + (ext16(press_hi_k, 0) << 4);
				w.value = p[31:0];
			end
		end
		return w;
	endfunction

	task automatic set_coeffs(input logic [47:0] t, input logic [47:0] lo,
			input logic [47:0] mid, input logic [47:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TEMP;      cfg_data <= t;   @(posedge clk);
		cfg_index <= CFG_PRESS_LOW; cfg_data <= lo;  @(posedge clk);
		cfg_index <= CFG_PRESS_MID; cfg_data <= mid; @(posedge clk);
		cfg_index <= CFG_PRESS_HIGH; cfg_data <= hi; @(posedge clk);
		cfg_we <= 1'b0;
		temp_k = t; press_lo_k = lo; press_mid_k = mid; press_hi_k = hi;
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// Drives one word and returns after the edge that accepts it.
	task automatic send_word(input logic action, input logic [19:0] raw,
			input bit known, input logic [31:0] value, input logic fault);
		comp_word_t w;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= action;
		in_ch.raw_sample <= raw;
		w = compensate(action, raw);
		if (known) begin
			w.value = value;
			w.fault = fault;
		end
		pending_words.push_back(w);
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			// Mostly temperature words, with a pressure word chosen at random one time in four.
			if ($urandom_range(3) != 0)
				send_word(1'b0, $urandom_range(20'hFFFFF), 0, '0, 1'b0);
			else
				send_word(1'b1, $urandom_range(20'hFFFFF), 0, '0, 1'b0);
			if (i == count / 2) begin
				in_ch.valid <= 1'b0;
				wait_drained();
			end
		end
		in_ch.valid <= 1'b0;
		wait_drained();
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()} >> 16);
	endfunction

	// Result side: check each accepted word, drive a random stall, run the watchdog.
	always @(posedge clk) begin
		comp_word_t want;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: timeout, %0d words outstanding", $time, pending_words.size());
				$display("tb_baro_temp_press_compensation NOT OK");
				$finish;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected word kind=%0d value=%h fault=%0d", $time,
						out_ch.result_kind, out_ch.comp_value, out_ch.divide_fault);
					mismatches++;
				end else begin
					want = pending_words.pop_front();
					if (want.kind) press_seen++; else temp_seen++;
					if (want.fault) faults_seen++;
					if (out_ch.result_kind !== want.kind || out_ch.comp_value !== want.value
							|| out_ch.divide_fault !== want.fault) begin
						$display("%0t: expected kind=%0d value=%h fault=%0d, got kind=%0d value=%h fault=%0d",
							$time, want.kind, want.value, want.fault, out_ch.result_kind,
							out_ch.comp_value, out_ch.divide_fault);
						mismatches++;
					end
				end
			end
		end
		out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
	localparam logic [47:0] TYP_LO = {16'd3024, 16'hD643, 16'd36477};
	localparam logic [47:0] TYP_MI = {16'hFFF9, 16'd140, 16'd2855};
	localparam logic [47:0] TYP_HI = {16'd6000, 16'hC6F8, 16'd15500};

	initial begin
		sample_row_t reset_rows[4];
		sample_row_t typ_rows[10];
		in_ch.valid = 1'b0;
		in_ch.action = 1'b0;
		in_ch.raw_sample = '0;
		out_ch.ready = 1'b0;
		temp_k = '0; press_lo_k = '0; press_mid_k = '0; press_hi_k = '0;
		held_fine = '0;

		// With all coefficients zero, temperature reads 0 and pressure hits the zero divisor.
		reset_rows = '{
			'{1'b1, 20'h00000, 1, 32'd0, 1'b1},
			'{1'b0, 20'h00000, 1, 32'd0, 1'b0},
			'{1'b0, 20'hFFFFF, 1, 32'd0, 1'b0},
			'{1'b1, 20'hFFFFF, 1, 32'd0, 1'b1}
		};
		typ_rows = '{
			'{1'b1, 20'd415148, 0, '0, 1'b0},
			'{1'b0, 20'd519888, 0, '0, 1'b0},
			'{1'b1, 20'd415148, 0, '0, 1'b0},
			'{1'b0, 20'h00000, 0, '0, 1'b0},
			'{1'b1, 20'h00000, 0, '0, 1'b0},
			'{1'b1, 20'hFFFFF, 0, '0, 1'b0},
			'{1'b0, 20'hFFFFF, 0, '0, 1'b0},
			'{1'b1, 20'h80000, 0, '0, 1'b0},
			'{1'b0, 20'h7FFFF, 0, '0, 1'b0},
			'{1'b1, 20'h55555, 0, '0, 1'b0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (reset_rows[i])
			send_word(reset_rows[i].action, reset_rows[i].raw, reset_rows[i].known,
				reset_rows[i].value, reset_rows[i].fault);
		in_ch.valid <= 1'b0;
		wait_drained();

		set_coeffs(TYP_T, TYP_LO, TYP_MI, TYP_HI);
		foreach (typ_rows[i])
			send_word(typ_rows[i].action, typ_rows[i].raw, 0, '0, 1'b0);
		in_ch.valid <= 1'b0;
		wait_drained();

		// Extreme coefficients: all ones, then every signed field at its most negative.
		set_coeffs('1, '1, '1, '1);
		send_word(1'b0, 20'hFFFFF, 0, '0, 1'b0);
		send_word(1'b1, 20'h00000, 0, '0, 1'b0);
		in_ch.valid <= 1'b0;
		wait_drained();
		set_coeffs({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'hFFFF},
			{3{16'h8000}}, {3{16'h8000}});
		send_word(1'b0, 20'h00000, 0, '0, 1'b0);
		send_word(1'b1, 20'hFFFFF, 0, '0, 1'b0);
		send_word(1'b0, 20'hFFFFF, 0, '0, 1'b0);
		send_word(1'b1, 20'h00001, 0, '0, 1'b0);
		in_ch.valid <= 1'b0;
		wait_drained();

		set_coeffs(TYP_T, TYP_LO, TYP_MI, TYP_HI);
		random_phase(300, 0, 0);
		set_coeffs(rand48(), rand48(), rand48(), rand48());
		random_phase(300, 70, 0);
		set_coeffs({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h0001},
			{3{16'h7FFF}}, {3{16'h7FFF}});
		random_phase(300, 0, 70);
		set_coeffs(TYP_T ^ {32'b0, 16'($urandom())}, TYP_LO, TYP_MI, rand48());
		random_phase(300, 36, 36);
		set_coeffs(rand48(), rand48() & 48'hFFFF_FFFF_0000, rand48(), rand48());
		random_phase(30, 36, 36);
		set_coeffs(rand48(), rand48(), rand48(), rand48());
		random_phase(300, 0, 0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d temperature and %0d pressure words (%0d divisor faults),",
			temp_seen, press_seen, faults_seen);
		$display("across reset, typical, extreme and random coefficients under varied idling.");
		if (mismatches == 0 && pending_words.size() == 0)
			$display("tb_baro_temp_press_compensation OK");
		else
			$display("tb_baro_temp_press_compensation NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
sv/btpc_pkg.sv
sv/btpc_ifs.sv
sv/btpc_div.sv
sv/btpc_dp.sv
sv/btpc_ctrl.sv
sv/baro_temp_press_compensation.sv
verif/tb_baro_temp_press_compensation.sv
